[design/u8vlm_pkg.sv]
// ----------------------------------------------------------------------------
// u8vlm_pkg
// Shared constants and nibble class tables for the UTF-8 validator.
// ----------------------------------------------------------------------------
package u8vlm_pkg;

    localparam int LANES_DEF  = 8;
    localparam int WORD_W     = 64;
    localparam int BYTE_CNT_W = 4;
    localparam int S_TDATA_W  = 72;   // data_word + byte_count, padded to bytes
    localparam int M_TDATA_W  = 16;   // lead_marks + error_so_far + stream_valid
    localparam int MARKS_W    = 8;

    localparam logic [7:0] CONT_MASK_BITS = 8'hC0;
    localparam logic [7:0] THIRD_MIN      = 8'hE0;
    localparam logic [7:0] FOURTH_MIN     = 8'hF0;
    localparam logic [7:0] NEED_CONT      = 8'h80;
    localparam logic [1:0] CONT_TAG       = 2'b10;

    // Class of the byte before the current one, by its high nibble.
    function automatic logic [7:0] lead_hi_class(input logic [3:0] nib);
        logic [7:0] r;
        case (nib)
            4'h8, 4'h9, 4'hA, 4'hB: r = 8'h80;
            4'hC:                   r = 8'h21;
            4'hD:                   r = 8'h01;
            4'hE:                   r = 8'h15;
            4'hF:                   r = 8'h49;
            default:                r = 8'h02;
        endcase
        return r;
    endfunction

    // Class of the byte before the current one, by its low nibble.
    function automatic logic [7:0] lead_lo_class(input logic [3:0] nib);
        logic [7:0] r;
        case (nib)
            4'h0:       r = 8'hE7;
            4'h1:       r = 8'hA3;
            4'h2, 4'h3: r = 8'h83;
            4'h4:       r = 8'h8B;
            4'hD:       r = 8'hDB;
            default:    r = 8'hCB;
        endcase
        return r;
    endfunction

    // Class of the current byte, by its high nibble.
    function automatic logic [7:0] next_hi_class(input logic [3:0] nib);
        logic [7:0] r;
        case (nib)
            4'h8:       r = 8'hE6;
            4'h9:       r = 8'hAE;
            4'hA, 4'hB: r = 8'hBA;
            default:    r = 8'h01;
        endcase
        return r;
    endfunction

endpackage

[design/u8vlm_front.sv]
// ----------------------------------------------------------------------------
// u8vlm_front
// Accepts input words, clamps the count and classifies each lane on its own.
// ----------------------------------------------------------------------------
module u8vlm_front
    import u8vlm_pkg::*;
#(
    parameter int LANES = LANES_DEF,
    parameter int CNT_W = $clog2(LANES + 1),
    parameter int ENT_W = 2 * LANES * 8 + CNT_W + 1 + LANES
)
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tlast,
    input  logic                 q_full,
    output logic                 q_push,
    output logic [ENT_W-1:0]     q_entry
);

    logic [WORD_W-1:0]     data_word;
    logic [BYTE_CNT_W-1:0] byte_count;
    logic [CNT_W-1:0]      cnt;
    logic [LANES*8-1:0]    lane_bytes;
    logic [LANES*8-1:0]    lane_class;
    logic [LANES-1:0]      marks;

    assign data_word  = s_axis_tdata[WORD_W-1:0];
    assign byte_count = s_axis_tdata[WORD_W +: BYTE_CNT_W];
    assign lane_bytes = data_word[LANES*8-1:0];

    assign cnt = (byte_count > BYTE_CNT_W'(LANES)) ? CNT_W'(LANES)
                                                   : byte_count[CNT_W-1:0];

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            lane_class[8*k +: 8] = next_hi_class(lane_bytes[8*k+4 +: 4]);
            marks[k] = (CNT_W'(k) < cnt) && (lane_bytes[8*k+6 +: 2] != CONT_TAG);
        end
    end

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;
    assign q_entry       = {lane_class, marks, s_axis_tlast, cnt, lane_bytes};

endmodule

[design/u8vlm_queue.sv]
// ----------------------------------------------------------------------------
// u8vlm_queue
// Two-entry queue between the classify front and the checking back.
// ----------------------------------------------------------------------------
module u8vlm_queue
    import u8vlm_pkg::*;
#(
    parameter int ENT_W = 2 * LANES_DEF * 8 + 5 + LANES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [ENT_W-1:0] push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [ENT_W-1:0] head_entry
);

    logic [ENT_W-1:0] mem [0:1];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    assign full       = fill_reg[1];
    assign head_valid = (fill_reg != 2'd0);
    assign head_entry = mem[rd_ptr_reg];

endmodule

[design/u8vlm_back.sv]
// ----------------------------------------------------------------------------
// u8vlm_back
// Checks each lane against its three predecessors, keeps stream history and
// the sticky error, and holds the result in an output register.
// ----------------------------------------------------------------------------
module u8vlm_back
    import u8vlm_pkg::*;
#(
    parameter int LANES = LANES_DEF,
    parameter int CNT_W = $clog2(LANES + 1),
    parameter int ENT_W = 2 * LANES * 8 + CNT_W + 1 + LANES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  logic [ENT_W-1:0]     head_entry,
    output logic                 pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tlast
);

    logic [LANES*8-1:0] lane_bytes;
    logic [CNT_W-1:0]   cnt;
    logic               last;
    logic [LANES-1:0]   marks;
    logic [LANES*8-1:0] lane_class;

    logic [7:0]  ext [0:LANES+2];
    logic [23:0] hist_new;
    logic        word_err;
    logic        unfinished;
    logic        err_out;

    logic [23:0]        hist_reg, hist_next;
    logic               err_reg, err_next;
    logic               out_valid_reg;
    logic [MARKS_W-1:0] marks_reg;
    logic               err_out_reg;
    logic               last_reg;
    logic               svalid_reg;

    assign {lane_class, marks, last, cnt, lane_bytes} = head_entry;

    assign pop = head_valid && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        logic [7:0] p1;
        logic [7:0] p2;
        logic [7:0] p3;
        logic [7:0] flags;
        logic [7:0] need;

        ext[0] = hist_reg[23:16];
        ext[1] = hist_reg[15:8];
        ext[2] = hist_reg[7:0];
        for (int k = 0; k < LANES; k++)
        begin
            ext[k+3] = lane_bytes[8*k +: 8];
        end

        word_err = 1'b0;
        for (int k = 0; k < LANES; k++)
        begin
            p1    = ext[k+2];
            p2    = ext[k+1];
            p3    = ext[k];
            flags = lead_hi_class(p1[7:4]) & lead_lo_class(p1[3:0])
                  & lane_class[8*k +: 8];
            need  = ((p2 >= THIRD_MIN) != (p3 >= FOURTH_MIN)) ? NEED_CONT : 8'h00;
            if ((CNT_W'(k) < cnt) && ((need ^ flags) != 8'h00))
            begin
                word_err = 1'b1;
            end
        end

        // history after this word: the three bytes ending at the last valid lane
        hist_new = hist_reg;
        for (int c = 1; c <= LANES; c++)
        begin
            if (cnt == CNT_W'(c))
            begin
                hist_new = {ext[c], ext[c+1], ext[c+2]};
            end
        end

        unfinished = (hist_new[7:0] >= CONT_MASK_BITS) || (hist_new[15:8] >= THIRD_MIN)
                  || (hist_new[23:16] >= FOURTH_MIN);
        err_out    = err_reg || word_err || (last && unfinished);
    end

    always_comb
    begin
        hist_next = hist_reg;
        err_next  = err_reg;
        if (pop)
        begin
            hist_next = last ? 24'h000000 : hist_new;
            err_next  = last ? 1'b0 : err_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg      <= 24'h000000;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hist_reg <= hist_next;
            err_reg  <= err_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            marks_reg   <= MARKS_W'(marks);
            err_out_reg <= err_out;
            last_reg    <= last;
            svalid_reg  <= last && !err_out;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = {6'b000000, svalid_reg, err_out_reg, marks_reg};

endmodule

[design/utf8_validate_lead_marks.sv]
// ----------------------------------------------------------------------------
// utf8_validate_lead_marks
// UTF-8 stream validator with per-byte lead marks.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one transfer per word of up to eight bytes, earliest
// byte in lane 0; tlast marks the final word of a stream. Output stream
// (m_axis): exactly one transfer per input transfer, in order, carrying the
// lead marks of the valid lanes, the sticky error flag and, on the last word
// (tlast), whether the whole stream was valid UTF-8.
// When the queue is empty, the word is classified and written into the
// two-entry queue, then checked against stream history and registered at the
// output. Throughput is one word per cycle while m_axis_tready stays high;
// the checking stage updates the three-byte history once per word.
// Reset clears the queue, the history (taken as ASCII) and the error flag;
// history and error also clear after every last word, starting a new stream.
// When the receiver stalls, the result holds in the output register, the
// queue fills, and s_axis_tready drops once both entries are taken.
// ----------------------------------------------------------------------------
module utf8_validate_lead_marks
    import u8vlm_pkg::*;
#(
    parameter int LANES = LANES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [63:0] data_word, [67:64] byte_count, [71:68] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tlast,   // last_word
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] lead_marks, [8] error_so_far, [9] stream_valid, [15:10] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tlast    // end_of_stream
);

    localparam int CNT_W = $clog2(LANES + 1);
    localparam int ENT_W = 2 * LANES * 8 + CNT_W + 1 + LANES;

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_head_valid;
    logic [ENT_W-1:0] q_push_entry;
    logic [ENT_W-1:0] q_head_entry;

    u8vlm_front #(
        .LANES (LANES),
        .CNT_W (CNT_W),
        .ENT_W (ENT_W)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_push_entry)
    );

    u8vlm_queue #(
        .ENT_W (ENT_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    u8vlm_back #(
        .LANES (LANES),
        .CNT_W (CNT_W),
        .ENT_W (ENT_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (q_head_valid),
        .head_entry    (q_head_entry),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
